@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSC_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) \
        else $error(msg);

`endif

@@ hdl/dsc_pkg.sv @@
// Shared widths, constants, types and helpers of the serial date converter.
package dsc_pkg;

    localparam int IN_W      = 56;
    localparam int DAY_W     = 22;
    localparam int SEC_W     = 17;
    localparam int YEAR_W    = 14;
    localparam int MON_W     = 4;
    localparam int MDAY_W    = 5;
    localparam int WDAY_W    = 3;
    localparam int YDAY_W    = 9;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SECF_W    = 6;

    localparam int FRAC_BITS_DEFAULT = 32;
    localparam int PIPE_DEPTH        = 7;

    localparam longint      SERIAL_DAY_LO = -657434;
    localparam longint      SERIAL_DAY_HI = 2958465;
    localparam int unsigned DAYS_TO_EPOCH = 693959;
    localparam int unsigned SECS_PER_DAY  = 86400;

    // Shift of the reciprocal multipliers used for division by constants.
    localparam int RECIP_SHIFT = 24;

    localparam logic [YDAY_W-1:0] MONTH_START [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [YDAY_W-1:0] day_of_year;
        logic [WDAY_W-1:0] day_of_week;
        logic              leap;
        logic [YDAY_W-1:0] day_idx;
    } year_info_t;

    // Remainder by seven: octal digits sum modulo seven since 8 = 1 (mod 7).
    function automatic logic [WDAY_W-1:0] mod7(input logic [DAY_W-1:0] x);
        logic [23:0] w;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [3:0]  s3;
        w  = 24'(x);
        s1 = '0;
        for (int i = 0; i < 8; i++)
        begin
            s1 = s1 + 6'(w[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        if (s3 >= 4'd7)
        begin
            s3 = s3 - 4'd7;
        end
        return s3[WDAY_W-1:0];
    endfunction

endpackage

@@ hdl/dsc_front.sv @@
// Input stage: range check, rounding to the second, split into day number and fraction.
module dsc_front #(
    parameter int FRACTION_BITS = dsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [dsc_pkg::IN_W-1:0] serial_date,
    output logic [dsc_pkg::DAY_W-1:0]       day_num,
    output logic [FRACTION_BITS-1:0]        frac,
    output logic                            in_range
);

    localparam int IN_W  = dsc_pkg::IN_W;
    localparam int DAY_W = dsc_pkg::DAY_W;

    localparam logic signed [IN_W-1:0] MAX_FIX =
        IN_W'(dsc_pkg::SERIAL_DAY_HI) <<< FRACTION_BITS;
    localparam logic signed [IN_W-1:0] MIN_FIX =
        IN_W'(dsc_pkg::SERIAL_DAY_LO) <<< FRACTION_BITS;
    localparam logic signed [IN_W-1:0] HALF =
        IN_W'(((64'd1 << FRACTION_BITS) + 64'd86400) / 64'd172800);

    logic signed [IN_W-1:0]    rounded;
    logic        [IN_W-1:0]    mag;
    logic        [DAY_W-1:0]   whole_days;
    logic        [DAY_W-1:0]   day_num_next, day_num_reg;
    logic [FRACTION_BITS-1:0]  frac_next, frac_reg;
    logic                      in_range_next, in_range_reg;

    always_comb
    begin
        // Zero counts as not positive: subtract the half second.
        if (!serial_date[IN_W-1] && (serial_date != '0))
        begin
            rounded = serial_date + HALF;
        end
        else
        begin
            rounded = serial_date - HALF;
        end
        mag        = rounded[IN_W-1] ? -rounded : rounded;
        whole_days = mag[FRACTION_BITS +: DAY_W];
        if (rounded[IN_W-1])
        begin
            day_num_next = DAY_W'(dsc_pkg::DAYS_TO_EPOCH) - whole_days;
        end
        else
        begin
            day_num_next = DAY_W'(dsc_pkg::DAYS_TO_EPOCH) + whole_days;
        end
        frac_next     = mag[FRACTION_BITS-1:0];
        in_range_next = (serial_date <= MAX_FIX) && (serial_date >= MIN_FIX);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            day_num_reg  <= day_num_next;
            frac_reg     <= frac_next;
            in_range_reg <= in_range_next;
        end
    end

    assign day_num  = day_num_reg;
    assign frac     = frac_reg;
    assign in_range = in_range_reg;

endmodule

@@ hdl/dsc_year.sv @@
// Day number to year, day within year and weekday, over five register stages.
module dsc_year (
    input  logic                       clk,
    input  logic                       en,
    input  logic [dsc_pkg::DAY_W-1:0]  day_num,
    output dsc_pkg::year_info_t        info
);

    localparam int DAY_W = dsc_pkg::DAY_W;
    localparam int SH    = dsc_pkg::RECIP_SHIFT;

    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned DAYS_100Y = 36524;
    localparam int unsigned DAYS_4Y   = 1461;
    localparam int unsigned DAYS_1Y   = 365;

    localparam logic [6:0]  R400  = 7'((64'd1 << SH) / 64'(DAYS_400Y));
    localparam logic [13:0] R1461 = 14'((64'd1 << SH) / 64'(DAYS_4Y));

    // Stage two: quotient estimate by 400 years, weekday
    logic [28:0]      prod400;
    logic [DAY_W-1:0] s2_day_reg;
    logic [4:0]       s2_y400e_next, s2_y400e_reg;
    logic [2:0]       s2_wday_next, s2_wday_reg;

    // Stage three: corrected 400 year count and remainder
    logic [22:0]      sub400;
    logic [18:0]      rem400;
    logic [4:0]       s3_y400_next, s3_y400_reg;
    logic [17:0]      s3_d1_next, s3_d1_reg;
    logic [2:0]       s3_wday_reg;

    // Stage four: century and quotient estimate by four years
    logic [1:0]       s4_cent_next, s4_cent_reg;
    logic [15:0]      s4_e_next, s4_e_reg;
    logic [29:0]      prod4y;
    logic [5:0]       s4_y4e_next, s4_y4e_reg;
    logic [4:0]       s4_y400_reg;
    logic [2:0]       s4_wday_reg;

    // Stage five: corrected four year count, day within the four years
    logic [16:0]      sub4y;
    logic [11:0]      rem4y;
    logic [10:0]      r4y;
    logic [5:0]       s5_y4_next, s5_y4_reg;
    logic             s5_leap4_next, s5_leap4_reg;
    logic [10:0]      s5_day4_next, s5_day4_reg;
    logic [4:0]       s5_y400_reg;
    logic [1:0]       s5_cent_reg;
    logic [2:0]       s5_wday_reg;

    // Stage six: year within the four and final fields
    logic [1:0]          yr;
    logic [10:0]         day_off;
    dsc_pkg::year_info_t info_next, info_reg;

    always_comb
    begin
        prod400       = 29'(day_num) * 29'(R400);
        s2_y400e_next = prod400[SH +: 5];
        s2_wday_next  = dsc_pkg::mod7(day_num - DAY_W'(1)) + 3'd1;
    end

    always_comb
    begin
        sub400 = 23'(s2_day_reg) - 23'(s2_y400e_reg) * 23'(DAYS_400Y);
        rem400 = sub400[18:0];
        if (rem400 >= 19'(DAYS_400Y))
        begin
            s3_y400_next = s2_y400e_reg + 5'd1;
            s3_d1_next   = 18'(rem400 - 19'(DAYS_400Y));
        end
        else
        begin
            s3_y400_next = s2_y400e_reg;
            s3_d1_next   = rem400[17:0];
        end
    end

    always_comb
    begin
        s4_cent_next = 2'(s3_d1_reg >= 18'(DAYS_100Y + 1))
                     + 2'(s3_d1_reg >= 18'(2 * DAYS_100Y + 1))
                     + 2'(s3_d1_reg >= 18'(3 * DAYS_100Y + 1));
        s4_e_next    = 16'(s3_d1_reg - 18'(s4_cent_next) * 18'(DAYS_100Y));
        prod4y       = 30'(s4_e_next) * 30'(R1461);
        s4_y4e_next  = prod4y[SH +: 6];
    end

    always_comb
    begin
        sub4y = 17'(s4_e_reg) - 17'(s4_y4e_reg) * 17'(DAYS_4Y);
        rem4y = sub4y[11:0];
        if (rem4y >= 12'(DAYS_4Y))
        begin
            s5_y4_next = s4_y4e_reg + 6'd1;
            r4y        = 11'(rem4y - 12'(DAYS_4Y));
        end
        else
        begin
            s5_y4_next = s4_y4e_reg;
            r4y        = rem4y[10:0];
        end
        // The first four years of a non-leading century lack the leap day.
        s5_leap4_next = !((s4_cent_reg != 2'd0) && (s5_y4_next == 6'd0));
        s5_day4_next  = s5_leap4_next ? r4y : r4y - 11'd1;
    end

    always_comb
    begin
        if (s5_leap4_reg)
        begin
            yr = 2'(s5_day4_reg >= 11'(DAYS_1Y + 1))
               + 2'(s5_day4_reg >= 11'(2 * DAYS_1Y + 1))
               + 2'(s5_day4_reg >= 11'(3 * DAYS_1Y + 1));
            if (yr == 2'd0)
            begin
                day_off = s5_day4_reg;
            end
            else
            begin
                day_off = s5_day4_reg - 11'd1 - 11'(yr) * 11'(DAYS_1Y);
            end
        end
        else
        begin
            yr = 2'(s5_day4_reg >= 11'(DAYS_1Y))
               + 2'(s5_day4_reg >= 11'(2 * DAYS_1Y))
               + 2'(s5_day4_reg >= 11'(3 * DAYS_1Y));
            day_off = s5_day4_reg - 11'(yr) * 11'(DAYS_1Y);
        end
        info_next.year        = 14'(s5_y400_reg) * 14'd400 + 14'(s5_cent_reg) * 14'd100
                              + 14'(s5_y4_reg) * 14'd4 + 14'(yr);
        info_next.day_idx     = 9'(day_off);
        info_next.day_of_year = 9'(day_off) + 9'd1;
        info_next.day_of_week = s5_wday_reg;
        info_next.leap        = s5_leap4_reg && (yr == 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_day_reg   <= day_num;
            s2_y400e_reg <= s2_y400e_next;
            s2_wday_reg  <= s2_wday_next;

            s3_y400_reg  <= s3_y400_next;
            s3_d1_reg    <= s3_d1_next;
            s3_wday_reg  <= s2_wday_reg;

            s4_cent_reg  <= s4_cent_next;
            s4_e_reg     <= s4_e_next;
            s4_y4e_reg   <= s4_y4e_next;
            s4_y400_reg  <= s3_y400_reg;
            s4_wday_reg  <= s3_wday_reg;

            s5_y4_reg    <= s5_y4_next;
            s5_leap4_reg <= s5_leap4_next;
            s5_day4_reg  <= s5_day4_next;
            s5_y400_reg  <= s4_y400_reg;
            s5_cent_reg  <= s4_cent_reg;
            s5_wday_reg  <= s4_wday_reg;

            info_reg     <= info_next;
        end
    end

    assign info = info_reg;

endmodule

@@ hdl/dsc_clock.sv @@
// Fraction of a day to hour, minute and second, over six register stages.
module dsc_clock #(
    parameter int FRACTION_BITS = dsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [FRACTION_BITS-1:0]     frac,
    output logic [dsc_pkg::HOUR_W-1:0]   hour,
    output logic [dsc_pkg::MIN_W-1:0]    minute,
    output logic [dsc_pkg::SECF_W-1:0]   second
);

    localparam int SEC_W  = dsc_pkg::SEC_W;
    localparam int HOUR_W = dsc_pkg::HOUR_W;
    localparam int MIN_W  = dsc_pkg::MIN_W;
    localparam int SECF_W = dsc_pkg::SECF_W;
    localparam int PROD_W = FRACTION_BITS + SEC_W;
    localparam int SH     = dsc_pkg::RECIP_SHIFT;

    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    localparam logic [12:0] R3600 = 13'((64'd1 << SH) / 64'(SECS_PER_HOUR));
    localparam logic [18:0] R60   = 19'((64'd1 << SH) / 64'(SECS_PER_MIN));

    logic [PROD_W-1:0] sprod;
    logic [SEC_W-1:0]  secs_next, secs_reg;

    logic [29:0]       hprod;
    logic [HOUR_W-1:0] hour_est_next, hour_est_reg;
    logic [SEC_W-1:0]  secs3_reg;

    logic [SEC_W-1:0]  hrem;
    logic [HOUR_W-1:0] hour4_next, hour4_reg;
    logic [11:0]       ms_next, ms_reg;

    logic [30:0]       mprod;
    logic [MIN_W-1:0]  min_est_next, min_est_reg;
    logic [HOUR_W-1:0] hour5_reg;
    logic [11:0]       ms5_reg;

    logic [11:0]       mrem;
    logic [MIN_W-1:0]  minute6_next, minute6_reg;
    logic [SECF_W-1:0] second6_next, second6_reg;
    logic [HOUR_W-1:0] hour6_reg;

    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  minute_reg;
    logic [SECF_W-1:0] second_reg;

    always_comb
    begin
        sprod     = PROD_W'(frac) * PROD_W'(dsc_pkg::SECS_PER_DAY);
        secs_next = sprod[FRACTION_BITS +: SEC_W];
    end

    always_comb
    begin
        hprod         = 30'(secs_reg) * 30'(R3600);
        hour_est_next = hprod[SH +: HOUR_W];
    end

    always_comb
    begin
        hrem = secs3_reg - SEC_W'(hour_est_reg) * SEC_W'(SECS_PER_HOUR);
        if (hrem >= SEC_W'(SECS_PER_HOUR))
        begin
            hour4_next = hour_est_reg + HOUR_W'(1);
            ms_next    = 12'(hrem - SEC_W'(SECS_PER_HOUR));
        end
        else
        begin
            hour4_next = hour_est_reg;
            ms_next    = 12'(hrem);
        end
    end

    always_comb
    begin
        mprod        = 31'(ms_reg) * 31'(R60);
        min_est_next = mprod[SH +: MIN_W];
    end

    always_comb
    begin
        mrem = ms5_reg - 12'(min_est_reg) * 12'(SECS_PER_MIN);
        if (mrem >= 12'(SECS_PER_MIN))
        begin
            minute6_next = min_est_reg + MIN_W'(1);
            second6_next = SECF_W'(mrem - 12'(SECS_PER_MIN));
        end
        else
        begin
            minute6_next = min_est_reg;
            second6_next = SECF_W'(mrem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            secs_reg     <= secs_next;

            hour_est_reg <= hour_est_next;
            secs3_reg    <= secs_reg;

            hour4_reg    <= hour4_next;
            ms_reg       <= ms_next;

            min_est_reg  <= min_est_next;
            hour5_reg    <= hour4_reg;
            ms5_reg      <= ms_reg;

            minute6_reg  <= minute6_next;
            second6_reg  <= second6_next;
            hour6_reg    <= hour5_reg;

            // hold one more stage to line up with the month lookup
            hour_reg     <= hour6_reg;
            minute_reg   <= minute6_reg;
            second_reg   <= second6_reg;
        end
    end

    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

@@ hdl/dsc_month.sv @@
// Day within year to month and day of month; final calendar register stage.
module dsc_month (
    input  logic                        clk,
    input  logic                        en,
    input  dsc_pkg::year_info_t         info,
    output logic [dsc_pkg::YEAR_W-1:0]  year,
    output logic [dsc_pkg::MON_W-1:0]   month,
    output logic [dsc_pkg::MDAY_W-1:0]  day_of_month,
    output logic [dsc_pkg::WDAY_W-1:0]  day_of_week,
    output logic [dsc_pkg::YDAY_W-1:0]  day_of_year
);

    localparam int MON_W  = dsc_pkg::MON_W;
    localparam int MDAY_W = dsc_pkg::MDAY_W;
    localparam int YDAY_W = dsc_pkg::YDAY_W;

    localparam logic [YDAY_W-1:0] LEAP_DAY_IDX = 9'd59;
    localparam logic [MON_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [MDAY_W-1:0] LEAP_MDAY    = 5'd29;

    logic                       feb29;
    logic [YDAY_W-1:0]          day_adj;
    logic [MON_W-1:0]           mon_cnt;
    logic [MON_W-1:0]           month_next, month_reg;
    logic [MDAY_W-1:0]          mday_next, mday_reg;
    logic [dsc_pkg::YEAR_W-1:0] year_reg;
    logic [dsc_pkg::WDAY_W-1:0] wday_reg;
    logic [YDAY_W-1:0]          yday_reg;

    always_comb
    begin
        feb29   = info.leap && (info.day_idx == LEAP_DAY_IDX);
        // drop the leap day so the common-year table applies after February
        day_adj = info.day_idx + 9'd1
                - ((info.leap && (info.day_idx > LEAP_DAY_IDX)) ? 9'd1 : 9'd0);
        mon_cnt = 4'd1;
        for (int k = 1; k < 12; k++)
        begin
            if (day_adj > dsc_pkg::MONTH_START[k])
            begin
                mon_cnt = mon_cnt + 4'd1;
            end
        end
        if (feb29)
        begin
            month_next = MONTH_FEB;
            mday_next  = LEAP_MDAY;
        end
        else
        begin
            month_next = mon_cnt;
            mday_next  = MDAY_W'(day_adj - dsc_pkg::MONTH_START[mon_cnt - 4'd1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            month_reg <= month_next;
            mday_reg  <= mday_next;
            year_reg  <= info.year;
            wday_reg  <= info.day_of_week;
            yday_reg  <= info.day_of_year;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;
    assign day_of_week  = wday_reg;
    assign day_of_year  = yday_reg;

endmodule

@@ hdl/date_serial_to_calendar_top.sv @@
// Serial date to calendar converter: takes one word per cycle when not stalled, and
// each result goes through seven register stages: input rounding and range check,
// the seconds multiply, then reciprocal estimates and corrections for the 400 year,
// century, four year, hour and minute divisions, and the month table lookup. A stall
// on the result side freezes the whole pipeline, and the input is stalled in that
// cycle only when a finished word waits at the output; otherwise a new word is taken
// every cycle. Out of range inputs give valid_res low and all other fields zero.
module date_serial_to_calendar_top #(
    parameter int FRACTION_BITS = dsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            date_valid,
    output logic                            date_stall,
    input  logic signed [dsc_pkg::IN_W-1:0] serial_date,
    output logic                            cal_valid,
    input  logic                            cal_stall,
    output logic                            valid_res,
    output logic [dsc_pkg::YEAR_W-1:0]      year,
    output logic [dsc_pkg::MON_W-1:0]       month,
    output logic [dsc_pkg::MDAY_W-1:0]      day_of_month,
    output logic [dsc_pkg::WDAY_W-1:0]      day_of_week,
    output logic [dsc_pkg::YDAY_W-1:0]      day_of_year,
    output logic [dsc_pkg::HOUR_W-1:0]      hour,
    output logic [dsc_pkg::MIN_W-1:0]       minute,
    output logic [dsc_pkg::SECF_W-1:0]      second
);

    localparam int PIPE_DEPTH = dsc_pkg::PIPE_DEPTH;

    logic                            adv;
    logic [PIPE_DEPTH-1:0]           valid_next, valid_reg;
    logic [PIPE_DEPTH-2:0]           ok_next, ok_reg;
    logic                            ok;

    logic [dsc_pkg::DAY_W-1:0]       day_num;
    logic [FRACTION_BITS-1:0]        frac;
    logic                            in_range;
    dsc_pkg::year_info_t             info;

    logic [dsc_pkg::YEAR_W-1:0]      year_w;
    logic [dsc_pkg::MON_W-1:0]       month_w;
    logic [dsc_pkg::MDAY_W-1:0]      mday_w;
    logic [dsc_pkg::WDAY_W-1:0]      wday_w;
    logic [dsc_pkg::YDAY_W-1:0]      yday_w;
    logic [dsc_pkg::HOUR_W-1:0]      hour_w;
    logic [dsc_pkg::MIN_W-1:0]       minute_w;
    logic [dsc_pkg::SECF_W-1:0]      second_w;

    // advance every stage unless a finished word is held at the output
    assign adv        = !(valid_reg[PIPE_DEPTH-1] && cal_stall);
    assign date_stall = !adv;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], date_valid};
    assign ok_next    = {ok_reg[PIPE_DEPTH-3:0], in_range};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg <= ok_next;
        end
    end

    dsc_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .en          (adv),
        .serial_date (serial_date),
        .day_num     (day_num),
        .frac        (frac),
        .in_range    (in_range)
    );

    dsc_year u_year (
        .clk     (clk),
        .en      (adv),
        .day_num (day_num),
        .info    (info)
    );

    dsc_month u_month (
        .clk          (clk),
        .en           (adv),
        .info         (info),
        .year         (year_w),
        .month        (month_w),
        .day_of_month (mday_w),
        .day_of_week  (wday_w),
        .day_of_year  (yday_w)
    );

    dsc_clock #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_clock (
        .clk    (clk),
        .en     (adv),
        .frac   (frac),
        .hour   (hour_w),
        .minute (minute_w),
        .second (second_w)
    );

    assign ok           = ok_reg[PIPE_DEPTH-2];
    assign cal_valid    = valid_reg[PIPE_DEPTH-1];
    assign valid_res    = ok;
    assign year         = ok ? year_w   : '0;
    assign month        = ok ? month_w  : '0;
    assign day_of_month = ok ? mday_w   : '0;
    assign day_of_week  = ok ? wday_w   : '0;
    assign day_of_year  = ok ? yday_w   : '0;
    assign hour         = ok ? hour_w   : '0;
    assign minute       = ok ? minute_w : '0;
    assign second       = ok ? second_w : '0;

endmodule

@@ hdl/dsc_checker.sv @@
// Port-level checks of the converter output, bound to the top level.
`include "assert_macros.svh"

module dsc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cal_valid,
    input logic                            cal_stall,
    input logic                            valid_res,
    input logic [dsc_pkg::YEAR_W-1:0]      year,
    input logic [dsc_pkg::MON_W-1:0]       month,
    input logic [dsc_pkg::MDAY_W-1:0]      day_of_month,
    input logic [dsc_pkg::WDAY_W-1:0]      day_of_week,
    input logic [dsc_pkg::YDAY_W-1:0]      day_of_year,
    input logic [dsc_pkg::HOUR_W-1:0]      hour,
    input logic [dsc_pkg::MIN_W-1:0]       minute,
    input logic [dsc_pkg::SECF_W-1:0]      second
);

    `DSC_ASSERT(a_range_zero, clk, rst_n,
        cal_valid && !valid_res |-> year == 0 && month == 0 && day_of_month == 0
            && day_of_week == 0 && day_of_year == 0 && hour == 0 && minute == 0
            && second == 0,
        "out of range word carries non-zero fields")

    `DSC_ASSERT(a_date_fields, clk, rst_n,
        cal_valid && valid_res |-> month >= 1 && month <= 12 && day_of_month >= 1
            && day_of_week >= 1 && day_of_year >= 1 && year >= 100 && year <= 9999,
        "calendar field out of its range")

    `DSC_ASSERT(a_time_fields, clk, rst_n,
        cal_valid && valid_res |-> hour <= 23 && minute <= 59 && second <= 59,
        "time field out of its range")

    `DSC_ASSERT(a_january, clk, rst_n,
        cal_valid && valid_res && month == 1 |-> day_of_year == 9'(day_of_month),
        "January day of year differs from day of month")

    `DSC_ASSERT_NEXT(a_stall_hold, clk, rst_n,
        cal_valid && cal_stall,
        cal_valid && $stable(year) && $stable(day_of_year) && $stable(second),
        "stalled result word changed")

endmodule

bind date_serial_to_calendar_top dsc_checker u_dsc_checker (.*);

@@ tb/date_serial_to_calendar_top_tb.sv @@
// Testbench for the serial date to calendar converter: stream of dates, calendar prediction.
module date_serial_to_calendar_top_tb;

    localparam int          IN_W          = dsc_pkg::IN_W;
    localparam int          YEAR_W        = dsc_pkg::YEAR_W;
    localparam int          MON_W         = dsc_pkg::MON_W;
    localparam int          MDAY_W        = dsc_pkg::MDAY_W;
    localparam int          WDAY_W        = dsc_pkg::WDAY_W;
    localparam int          YDAY_W        = dsc_pkg::YDAY_W;
    localparam int          HOUR_W        = dsc_pkg::HOUR_W;
    localparam int          MIN_W         = dsc_pkg::MIN_W;
    localparam int          SECF_W        = dsc_pkg::SECF_W;
    localparam int          PIPE_DEPTH    = dsc_pkg::PIPE_DEPTH;
    localparam longint      SERIAL_DAY_LO = dsc_pkg::SERIAL_DAY_LO;
    localparam longint      SERIAL_DAY_HI = dsc_pkg::SERIAL_DAY_HI;
    localparam int unsigned DAYS_TO_EPOCH = dsc_pkg::DAYS_TO_EPOCH;

    localparam int     FRAC_BITS      = dsc_pkg::FRAC_BITS_DEFAULT;
    localparam longint FRAC_ONE       = longint'(1) << FRAC_BITS;
    localparam longint HALF_SEC_FIX   = ((longint'(1) << FRAC_BITS) + 86400) / 172800;
    localparam int     RANDOM_DATES   = 1800;
    localparam int     DRAIN_CYCLES   = 2 * PIPE_DEPTH + 4;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_PRINTED    = 100;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HOLD} stall_mode_t;

    typedef struct packed {
        logic              valid_res;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] day_of_month;
        logic [WDAY_W-1:0] day_of_week;
        logic [YDAY_W-1:0] day_of_year;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SECF_W-1:0] second;
    } cal_fields_t;

    class calendar_scoreboard_t;
        longint      pending_serial[$];
        cal_fields_t pending_fields[$];
        longint      current_serial;
        int          mismatches;
        int          converted;
        int          in_range;

        function new();
            mismatches = 0;
            converted  = 0;
            in_range   = 0;
        endfunction

        // Gregorian breakdown of a fixed point serial date.
        function cal_fields_t calendar_of(input logic signed [IN_W-1:0] sd);
            cal_fields_t f;
            longint      s, rounded, mag, days, d, era, century, quad, yr, day_in, mday;
            longint      frac, secs;
            int          mon;
            bit          leap4;
            f = '0;
            s = sd;
            if (s > SERIAL_DAY_HI * FRAC_ONE || s < SERIAL_DAY_LO * FRAC_ONE)
            begin
                return f;
            end
            rounded = (s > 0) ? s + HALF_SEC_FIX : s - HALF_SEC_FIX;
            mag     = (rounded < 0) ? -rounded : rounded;
            days    = mag >> FRAC_BITS;
            if (rounded < 0)
            begin
                days = -days;
            end
            frac = mag & (FRAC_ONE - 1);
            secs = (frac * 86400) >> FRAC_BITS;

            d = days + longint'(DAYS_TO_EPOCH);
            f.day_of_week = WDAY_W'((d - 1) % 7 + 1);
            era     = d / 146097;
            d       = d % 146097;
            century = (d - 1) / 36524;
            leap4   = 1'b1;
            if (century != 0)
            begin
                d    = (d - 1) % 36524;
                quad = (d + 1) / 1461;
                if (quad != 0)
                begin
                    day_in = (d + 1) % 1461;
                end
                else
                begin
                    // first four years of a plain century hold no leap year
                    leap4  = 1'b0;
                    day_in = d;
                end
            end
            else
            begin
                quad   = d / 1461;
                day_in = d % 1461;
            end

            if (leap4)
            begin
                yr = (day_in - 1) / 365;
                if (yr != 0)
                begin
                    day_in = (day_in - 1) % 365;
                end
            end
            else
            begin
                yr     = day_in / 365;
                day_in = day_in % 365;
            end

            f.year        = YEAR_W'(era * 400 + century * 100 + quad * 4 + yr);
            f.day_of_year = YDAY_W'(day_in + 1);

            if (yr == 0 && leap4 && day_in == 59)
            begin
                mon  = 2;
                mday = 29;
            end
            else
            begin
                // fold the leap day away before the month table walk
                if (yr == 0 && leap4 && day_in >= 60)
                begin
                    day_in--;
                end
                day_in++;
                mon = 1;
                while (mon < 12 && day_in > longint'(dsc_pkg::MONTH_START[mon]))
                begin
                    mon++;
                end
                mday = day_in - longint'(dsc_pkg::MONTH_START[mon - 1]);
            end
            f.valid_res    = 1'b1;
            f.month        = MON_W'(mon);
            f.day_of_month = MDAY_W'(mday);
            f.hour         = HOUR_W'(secs / 3600);
            f.minute       = MIN_W'((secs / 60) % 60);
            f.second       = SECF_W'(secs % 60);
            return f;
        endfunction

        function void note_date(input logic signed [IN_W-1:0] sd);
            pending_serial.push_back(longint'(sd));
            pending_fields.push_back(calendar_of(sd));
        endfunction

        function int outstanding();
            return pending_fields.size();
        endfunction

        task report(input string what, input logic [15:0] got_v, input logic [15:0] want_v);
            if (mismatches < MAX_PRINTED)
            begin
                $display("MISMATCH %s: serial %0d got %0d expected %0d",
                         what, current_serial, got_v, want_v);
            end
            mismatches++;
        endtask

        task check_result(input cal_fields_t got);
            cal_fields_t want;
            if (pending_fields.size() == 0)
            begin
                current_serial = 0;
                report("calendar word with nothing pending", 16'(got.year), 16'd0);
                return;
            end
            want           = pending_fields.pop_front();
            current_serial = pending_serial.pop_front();
            converted++;
            if (want.valid_res)
            begin
                in_range++;
            end
            if (got.valid_res !== want.valid_res)
                report("valid_res", 16'(got.valid_res), 16'(want.valid_res));
            if (got.year !== want.year)
                report("year", 16'(got.year), 16'(want.year));
            if (got.month !== want.month)
                report("month", 16'(got.month), 16'(want.month));
            if (got.day_of_month !== want.day_of_month)
                report("day_of_month", 16'(got.day_of_month), 16'(want.day_of_month));
            if (got.day_of_week !== want.day_of_week)
                report("day_of_week", 16'(got.day_of_week), 16'(want.day_of_week));
            if (got.day_of_year !== want.day_of_year)
                report("day_of_year", 16'(got.day_of_year), 16'(want.day_of_year));
            if (got.hour !== want.hour)
                report("hour", 16'(got.hour), 16'(want.hour));
            if (got.minute !== want.minute)
                report("minute", 16'(got.minute), 16'(want.minute));
            if (got.second !== want.second)
                report("second", 16'(got.second), 16'(want.second));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     date_valid;
    logic                     date_stall;
    logic signed [IN_W-1:0]   serial_date;
    logic                     cal_valid;
    logic                     cal_stall;
    logic                     valid_res;
    logic [YEAR_W-1:0]        year;
    logic [MON_W-1:0]         month;
    logic [MDAY_W-1:0]        day_of_month;
    logic [WDAY_W-1:0]        day_of_week;
    logic [YDAY_W-1:0]        day_of_year;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SECF_W-1:0]        second;

    calendar_scoreboard_t sb;
    int                   longest_hold = 0;

    date_serial_to_calendar_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .date_valid(date_valid),
        .date_stall(date_stall),
        .serial_date(serial_date),
        .cal_valid(cal_valid),
        .cal_stall(cal_stall),
        .valid_res(valid_res),
        .year(year),
        .month(month),
        .day_of_month(day_of_month),
        .day_of_week(day_of_week),
        .day_of_year(day_of_year),
        .hour(hour),
        .minute(minute),
        .second(second)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        cal_fields_t got;
        if (rst_n && date_valid && !date_stall)
        begin
            sb.note_date(serial_date);
        end
        if (rst_n && cal_valid && !cal_stall)
        begin
            got.valid_res    = valid_res;
            got.year         = year;
            got.month        = month;
            got.day_of_month = day_of_month;
            got.day_of_week  = day_of_week;
            got.day_of_year  = day_of_year;
            got.hour         = hour;
            got.minute       = minute;
            got.second       = second;
            sb.check_result(got);
        end
    end

    // Receiver back-pressure: segments of free flow, random, periodic and long holds.
    initial
    begin : receiver
        stall_mode_t mode;
        int          seg;
        int          len;
        int          period;
        int          on_cycles;
        bit          stall_now;
        seg = 0;
        @(posedge rst_n);
        forever
        begin
            // force one long hold early so that the pipeline fills and stalls its input
            mode      = (seg == 3) ? STALL_HOLD : stall_mode_t'($urandom_range(0, 3));
            period    = $urandom_range(2, 6);
            on_cycles = $urandom_range(1, period - 1);
            len       = (mode == STALL_HOLD) ? $urandom_range(40, 80) : $urandom_range(20, 120);
            if (mode == STALL_HOLD && len > longest_hold)
            begin
                longest_hold = len;
            end
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    STALL_NONE:    stall_now = 1'b0;
                    STALL_RANDOM:  stall_now = ($urandom_range(0, 99) < 40);
                    STALL_PATTERN: stall_now = ((i % period) < on_cycles);
                    default:       stall_now = 1'b1;
                endcase
                @(negedge clk);
                cal_stall <= stall_now;
            end
            seg++;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((date_valid && !date_stall) || (cal_valid && !cal_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Hold the word until the block takes it.
    task automatic send_date(input longint v);
        @(negedge clk);
        date_valid  <= 1'b1;
        serial_date <= IN_W'(v);
        @(posedge clk);
        while (date_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        date_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    function automatic longint random_serial();
        logic [IN_W-1:0] w;
        longint          days;
        longint          frac;
        longint          secs;
        int              kind;
        int              offs[8];
        offs = '{0, 1, 58, 59, 60, 61, 364, 365};
        kind = $urandom_range(0, 99);
        frac = longint'($urandom) & (FRAC_ONE - 1);
        if (kind < 55)
        begin
            days = SERIAL_DAY_LO
                 + longint'($urandom_range(0, int'(SERIAL_DAY_HI - SERIAL_DAY_LO)));
            return days * FRAC_ONE + frac;
        end
        else if (kind < 75)
        begin
            // land near year, leap day, century and 400 year edges
            days = longint'($urandom_range(0, 24)) * 146097
                 + longint'($urandom_range(0, 3)) * 36524
                 + longint'($urandom_range(0, 24)) * 1461
                 + longint'($urandom_range(0, 3)) * 365
                 + longint'(offs[$urandom_range(0, 7)]) + longint'($urandom_range(0, 2)) - 1
                 - longint'(DAYS_TO_EPOCH);
            return days * FRAC_ONE + frac;
        end
        else if (kind < 85)
        begin
            case ($urandom_range(0, 2))
                0:       days = SERIAL_DAY_LO;
                1:       days = SERIAL_DAY_HI;
                default: days = 0;
            endcase
            return days * FRAC_ONE + longint'($urandom_range(0, int'(8 * HALF_SEC_FIX)))
                   - 4 * HALF_SEC_FIX;
        end
        else if (kind < 90)
        begin
            // straddle whole seconds so that rounding decides
            days = SERIAL_DAY_LO
                 + longint'($urandom_range(0, int'(SERIAL_DAY_HI - SERIAL_DAY_LO)));
            secs = longint'($urandom_range(0, 86399));
            frac = ((secs * FRAC_ONE) / 86400 + longint'($urandom_range(0, 60000)) - 30000)
                 & (FRAC_ONE - 1);
            return days * FRAC_ONE + frac;
        end
        w = IN_W'({$urandom, $urandom});
        return longint'(signed'(w));
    endfunction

    initial
    begin : stimulus
        longint dates[$];
        int     burst;
        rst_n       = 1'b0;
        date_valid  = 1'b0;
        serial_date = '0;
        cal_stall   = 1'b0;
        sb          = new();

        dates.push_back(0);
        dates.push_back(-(FRAC_ONE + FRAC_ONE / 4));
        dates.push_back(FRAC_ONE);
        dates.push_back(-FRAC_ONE);
        dates.push_back(1);
        dates.push_back(-1);
        dates.push_back(HALF_SEC_FIX - 1);
        dates.push_back(HALF_SEC_FIX);
        dates.push_back(-HALF_SEC_FIX);
        dates.push_back(FRAC_ONE - 1);
        dates.push_back(-(FRAC_ONE - 1));
        dates.push_back(SERIAL_DAY_LO * FRAC_ONE);
        dates.push_back(SERIAL_DAY_LO * FRAC_ONE - 1);
        dates.push_back(SERIAL_DAY_HI * FRAC_ONE);
        dates.push_back(SERIAL_DAY_HI * FRAC_ONE + 1);
        dates.push_back(SERIAL_DAY_HI * FRAC_ONE - 1);
        dates.push_back(-(longint'(1) << (IN_W - 1)));
        dates.push_back((longint'(1) << (IN_W - 1)) - 1);
        dates.push_back(59 * FRAC_ONE);
        dates.push_back(60 * FRAC_ONE);
        dates.push_back(61 * FRAC_ONE);
        dates.push_back(36585 * FRAC_ONE + FRAC_ONE / 2);
        dates.push_back(36586 * FRAC_ONE - HALF_SEC_FIX - 1);
        for (int i = 0; i < RANDOM_DATES; i++)
        begin
            dates.push_back(random_serial());
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (dates.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && dates.size() > 0)
            begin
                send_date(dates.pop_front());
                burst--;
            end
            // some bursts run straight into the next
            if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 12));
            end
        end
        @(negedge clk);
        date_valid <= 1'b0;

        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d date words, %0d in range and %0d out of range.",
                 sb.converted, sb.in_range, sb.converted - sb.in_range);
        $display("Receiver stalls included a hold of %0d cycles; %0d field mismatches.",
                 longest_hold, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
